FILE: rtl/kgrq_pkg.sv
package kgrq_pkg;

	localparam int GRID_COLS     = 64;
	localparam int GRID_ROWS     = 48;
	localparam int MAX_KEYPOINTS = 1024;
	localparam int CELL_CAPACITY = 16;
	localparam int MAX_MATCHES   = 64;

	localparam int FRAC_BITS = 20;
	// (18-bit signed offset) x (17-bit signed inverse)
	localparam int PROD_W    = 35;
	localparam int Q_W       = PROD_W - FRAC_BITS;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_OUTSIDE = 3'd1;
	localparam logic [2:0] ST_CFULL   = 3'd2;
	localparam logic [2:0] ST_SFULL   = 3'd3;
	localparam logic [2:0] ST_TRUNC   = 3'd4;
	localparam logic [2:0] ST_NOMATCH = 3'd5;

	localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
	localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
	localparam logic [1:0] CFG_INV_W    = 2'd2;
	localparam logic [1:0] CFG_INV_H    = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic [2:0]         point_level;
		logic [11:0]        radius;
		logic signed [3:0]  min_level;
		logic signed [3:0]  max_level;
	} cmd_t;

	typedef struct packed {
		logic [9:0] feature_index;
		logic [5:0] cell_col;
		logic [5:0] cell_row;
		logic [2:0] status;
		logic       last;
	} result_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [2:0]         level;
	} key_t;

	function automatic logic signed [Q_W-1:0] floor_q(input logic signed [PROD_W-1:0] v);
		floor_q = v[PROD_W-1:FRAC_BITS];
	endfunction

	function automatic logic signed [Q_W-1:0] ceil_q(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] t;
		t = v + PROD_W'((1 << FRAC_BITS) - 1);
		ceil_q = t[PROD_W-1:FRAC_BITS];
	endfunction

	// nearest, half away from zero
	function automatic logic signed [Q_W-1:0] round_q(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] t;
		logic [Q_W-1:0]    q;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		t = mag + PROD_W'(1 << (FRAC_BITS - 1));
		q = t[PROD_W-1:FRAC_BITS];
		round_q = v[PROD_W-1] ? $signed(Q_W'(-q)) : $signed(q);
	endfunction

endpackage

FILE: rtl/keypoint_grid_radius_query_core.sv
// Channel   Direction  Handshake                        Payload
// command   in         start & !busy                    cmd (kgrq_pkg::cmd_t)
// result    out        result_valid, one-cycle strobe   result (kgrq_pkg::result_t)
// config    in         cfg_valid & cfg_ready            cfg_index, cfg_data
//
// Clear: a sweep over all GRID_COLS*GRID_ROWS (3072) cells of the fill memory, then one result.
// The same sweep runs after reset; busy is high throughout, config writes are still taken.
// Insert: multiply, round, fill read, update. Query: setup (S_Q1 to S_Q4), then for each cell
// visited a fill read, and per slot read: slot memory, then keypoint memory, then test; then close.
// One item at a time; results are strobed and cannot be held off by the receiver.
module keypoint_grid_radius_query_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  kgrq_pkg::cmd_t    cmd,
	output logic              result_valid,
	output kgrq_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import kgrq_pkg::*;

	localparam int NCELLS = GRID_COLS * GRID_ROWS;
	localparam int NSLOTS = NCELLS * CELL_CAPACITY;
	localparam int CELL_W = $clog2(NCELLS);
	localparam int SLOT_W = $clog2(NSLOTS);
	localparam int KEY_W  = $clog2(MAX_KEYPOINTS);
	localparam int KC_W   = $clog2(MAX_KEYPOINTS + 1);
	localparam int FILL_W = $clog2(CELL_CAPACITY + 1);
	localparam int N_W    = $clog2(MAX_MATCHES + 1);
	localparam int COL_W  = $clog2(GRID_COLS);
	localparam int ROW_W  = $clog2(GRID_ROWS);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_INS1, S_INS2, S_INS3, S_INS4,
		S_Q1, S_Q2, S_Q3, S_Q4, S_CELL, S_FILL, S_SLOT, S_KEY, S_TEST, S_DONE
	} state_t;

	state_t state_q;
	cmd_t   cmd_q;

	logic signed [15:0] origin_x_q, origin_y_q;
	logic [15:0]        inv_w_q, inv_h_q;

	logic [KC_W-1:0]   key_count_q;
	logic [CELL_W-1:0] clr_cnt_q;
	logic              clr_op_q;
	logic [KEY_W-1:0]  idx_q, k_q, pend_q;
	logic [CELL_W-1:0] cell_q;
	logic [COL_W-1:0]  col_q, col_lo_q, col_hi_q;
	logic [ROW_W-1:0]  row_q, row_lo_q, row_hi_q;
	logic [FILL_W-1:0] fill_q, j_q;
	logic [N_W-1:0]    n_q;
	logic signed [Q_W-1:0]    lo_x_q, lo_y_q;
	logic signed [PROD_W-1:0] prod_x_q, prod_y_q;

	key_t              key_mem [MAX_KEYPOINTS];
	logic [FILL_W-1:0] fill_mem [NCELLS];
	logic [KEY_W-1:0]  slot_mem [NSLOTS];
	key_t              key_rd_q;
	logic [FILL_W-1:0] fill_rd_q;
	logic [KEY_W-1:0]  slot_rd_q;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			inv_w_q    <= 16'd6554;
			inv_h_q    <= 16'd6554;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ORIGIN_X: origin_x_q <= $signed(cfg_data);
				CFG_ORIGIN_Y: origin_y_q <= $signed(cfg_data);
				CFG_INV_W:    inv_w_q    <= cfg_data;
				CFG_INV_H:    inv_h_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	// shared multipliers
	logic signed [17:0] dx, dy, rad, mul_ax, mul_ay;
	logic signed [PROD_W-1:0] prod_x_d, prod_y_d;
	always_comb begin
		dx  = 18'(cmd_q.point_x) - 18'(origin_x_q);
		dy  = 18'(cmd_q.point_y) - 18'(origin_y_q);
		rad = $signed({6'd0, cmd_q.radius});
		unique case (state_q)
			S_Q1: begin
				mul_ax = dx - rad;
				mul_ay = dy - rad;
			end
			S_Q2: begin
				mul_ax = dx + rad;
				mul_ay = dy + rad;
			end
			default: begin
				mul_ax = dx;
				mul_ay = dy;
			end
		endcase
		prod_x_d = PROD_W'(mul_ax * $signed({1'b0, inv_w_q}));
		prod_y_d = PROD_W'(mul_ay * $signed({1'b0, inv_h_q}));
	end

	// insert binning
	logic signed [Q_W-1:0] col_r, row_r;
	logic                  outside;
	always_comb begin
		col_r   = round_q(prod_x_q);
		row_r   = round_q(prod_y_q);
		outside = (col_r < 0) || (col_r >= Q_W'(GRID_COLS)) ||
		          (row_r < 0) || (row_r >= Q_W'(GRID_ROWS));
	end

	// query box
	logic signed [Q_W-1:0] hi_x, hi_y, c0, c1, r0, r1;
	logic                  box_empty;
	always_comb begin
		hi_x = ceil_q(prod_x_q);
		hi_y = ceil_q(prod_y_q);
		c0 = (lo_x_q < 0) ? '0 : lo_x_q;
		r0 = (lo_y_q < 0) ? '0 : lo_y_q;
		c1 = (hi_x > Q_W'(GRID_COLS - 1)) ? Q_W'(GRID_COLS - 1) : hi_x;
		r1 = (hi_y > Q_W'(GRID_ROWS - 1)) ? Q_W'(GRID_ROWS - 1) : hi_y;
		box_empty = (c0 > c1) || (r0 > r1);
	end

	// keypoint test
	logic signed [16:0] ex, ey;
	logic [16:0]        ax, ay;
	logic signed [4:0]  lvl5;
	logic               filt, lvl_ok, hit;
	always_comb begin
		ex   = 17'(key_rd_q.x) - 17'(cmd_q.point_x);
		ey   = 17'(key_rd_q.y) - 17'(cmd_q.point_y);
		ax   = ex[16] ? 17'(-ex) : 17'(ex);
		ay   = ey[16] ? 17'(-ey) : 17'(ey);
		lvl5 = $signed({2'b00, key_rd_q.level});
		filt = (cmd_q.min_level > 0) || (cmd_q.max_level >= 0);
		lvl_ok = !filt || ((lvl5 >= 5'(cmd_q.min_level)) && (lvl5 <= 5'(cmd_q.max_level)));
		hit  = lvl_ok && (ax < {5'd0, cmd_q.radius}) && (ay < {5'd0, cmd_q.radius});
	end

	// cell walk step
	logic              row_more, col_more;
	logic [CELL_W-1:0] next_col_cell;
	always_comb begin
		row_more = (row_q != row_hi_q);
		col_more = (col_q != col_hi_q);
		next_col_cell = cell_q + CELL_W'(GRID_ROWS) - CELL_W'(row_hi_q) + CELL_W'(row_lo_q);
	end

	// memory ports
	logic              key_we, fill_we, slot_we;
	logic [CELL_W-1:0] fill_wa;
	logic [FILL_W-1:0] fill_wd;
	logic [SLOT_W-1:0] slot_ra, slot_wa;
	always_comb begin
		key_we  = (state_q == S_INS1) && (key_count_q < KC_W'(MAX_KEYPOINTS));
		fill_we = (state_q == S_CLEAR) ||
		          ((state_q == S_INS4) && (fill_rd_q < FILL_W'(CELL_CAPACITY)));
		slot_we = (state_q == S_INS4) && (fill_rd_q < FILL_W'(CELL_CAPACITY));
		fill_wa = (state_q == S_CLEAR) ? clr_cnt_q : cell_q;
		fill_wd = (state_q == S_CLEAR) ? '0 : FILL_W'(fill_rd_q + 1'b1);
		slot_ra = SLOT_W'(cell_q) * SLOT_W'(CELL_CAPACITY) + SLOT_W'(j_q);
		slot_wa = SLOT_W'(cell_q) * SLOT_W'(CELL_CAPACITY) + SLOT_W'(fill_rd_q);
	end

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[key_count_q[KEY_W-1:0]] <= '{x: cmd_q.point_x, y: cmd_q.point_y,
			                                     level: cmd_q.point_level};
		key_rd_q <= key_mem[slot_rd_q];
	end

	always_ff @(posedge clk) begin
		if (fill_we)
			fill_mem[fill_wa] <= fill_wd;
		fill_rd_q <= fill_mem[cell_q];
	end

	always_ff @(posedge clk) begin
		if (slot_we)
			slot_mem[slot_wa] <= idx_q;
		slot_rd_q <= slot_mem[slot_ra];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			key_count_q  <= '0;
			clr_cnt_q    <= '0;
			clr_op_q     <= 1'b0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			result_valid <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == CELL_W'(NCELLS - 1)) begin
						state_q <= S_IDLE;
						if (clr_op_q) begin
							result_valid <= 1'b1;
							result       <= '{last: 1'b1, status: ST_OK, default: '0};
						end
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						unique case (cmd.op)
							OP_CLEAR: begin
								key_count_q <= '0;
								clr_cnt_q   <= '0;
								clr_op_q    <= 1'b1;
								state_q     <= S_CLEAR;
							end
							OP_INSERT: state_q <= S_INS1;
							OP_QUERY:  state_q <= S_Q1;
							default:   ;
						endcase
					end
				end
				S_INS1: begin
					if (key_count_q >= KC_W'(MAX_KEYPOINTS)) begin
						result_valid <= 1'b1;
						result       <= '{last: 1'b1, status: ST_SFULL, default: '0};
						state_q      <= S_IDLE;
					end else begin
						idx_q       <= key_count_q[KEY_W-1:0];
						key_count_q <= key_count_q + 1'b1;
						prod_x_q    <= prod_x_d;
						prod_y_q    <= prod_y_d;
						state_q     <= S_INS2;
					end
				end
				S_INS2: begin
					col_q  <= col_r[COL_W-1:0];
					row_q  <= row_r[ROW_W-1:0];
					cell_q <= CELL_W'(col_r[COL_W-1:0]) * CELL_W'(GRID_ROWS) +
					          CELL_W'(row_r[ROW_W-1:0]);
					if (outside) begin
						result_valid <= 1'b1;
						result       <= '{feature_index: 10'(idx_q), status: ST_OUTSIDE,
						                 last: 1'b1, default: '0};
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_INS3;
					end
				end
				S_INS3: state_q <= S_INS4;
				S_INS4: begin
					result_valid <= 1'b1;
					result       <= '{feature_index: 10'(idx_q), cell_col: 6'(col_q),
					                 cell_row: 6'(row_q),
					                 status: (fill_rd_q < FILL_W'(CELL_CAPACITY)) ? ST_OK
					                                                              : ST_CFULL,
					                 last: 1'b1};
					state_q      <= S_IDLE;
				end
				S_Q1: begin
					prod_x_q <= prod_x_d;
					prod_y_q <= prod_y_d;
					state_q  <= S_Q2;
				end
				S_Q2: begin
					lo_x_q   <= floor_q(prod_x_q);
					lo_y_q   <= floor_q(prod_y_q);
					prod_x_q <= prod_x_d;
					prod_y_q <= prod_y_d;
					state_q  <= S_Q3;
				end
				S_Q3: begin
					col_lo_q <= c0[COL_W-1:0];
					col_hi_q <= c1[COL_W-1:0];
					row_lo_q <= r0[ROW_W-1:0];
					row_hi_q <= r1[ROW_W-1:0];
					n_q      <= '0;
					if (box_empty) begin
						result_valid <= 1'b1;
						result       <= '{status: ST_NOMATCH, last: 1'b1, default: '0};
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_Q4;
					end
				end
				S_Q4: begin
					col_q   <= col_lo_q;
					row_q   <= row_lo_q;
					cell_q  <= CELL_W'(col_lo_q) * CELL_W'(GRID_ROWS) + CELL_W'(row_lo_q);
					state_q <= S_CELL;
				end
				S_CELL: state_q <= S_FILL;
				S_FILL: begin
					fill_q <= (fill_rd_q > FILL_W'(CELL_CAPACITY)) ? FILL_W'(CELL_CAPACITY)
					                                                : fill_rd_q;
					j_q    <= '0;
					if (fill_rd_q != '0) begin
						state_q <= S_SLOT;
					end else if (row_more) begin
						row_q   <= row_q + 1'b1;
						cell_q  <= cell_q + 1'b1;
						state_q <= S_CELL;
					end else if (col_more) begin
						col_q   <= col_q + 1'b1;
						row_q   <= row_lo_q;
						cell_q  <= next_col_cell;
						state_q <= S_CELL;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_SLOT: state_q <= S_KEY;
				S_KEY: begin
					k_q     <= slot_rd_q;
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (hit && (n_q == N_W'(MAX_MATCHES))) begin
						result_valid <= 1'b1;
						result       <= '{feature_index: 10'(pend_q), status: ST_TRUNC,
						                 last: 1'b1, default: '0};
						state_q      <= S_IDLE;
					end else begin
						if (hit) begin
							// hold each match until the next one shows it is not the last
							if (n_q != '0) begin
								result_valid <= 1'b1;
								result       <= '{feature_index: 10'(pend_q), status: ST_OK,
								                 default: '0};
							end
							pend_q <= k_q;
							n_q    <= n_q + 1'b1;
						end
						j_q <= j_q + 1'b1;
						if (FILL_W'(j_q + 1'b1) != fill_q) begin
							state_q <= S_SLOT;
						end else if (row_more) begin
							row_q   <= row_q + 1'b1;
							cell_q  <= cell_q + 1'b1;
							state_q <= S_CELL;
						end else if (col_more) begin
							col_q   <= col_q + 1'b1;
							row_q   <= row_lo_q;
							cell_q  <= next_col_cell;
							state_q <= S_CELL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					result_valid <= 1'b1;
					if (n_q == '0)
						result <= '{status: ST_NOMATCH, last: 1'b1, default: '0};
					else
						result <= '{feature_index: 10'(pend_q), status: ST_OK, last: 1'b1,
						            default: '0};
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= KC_W'(MAX_KEYPOINTS))
		else $error("keypoint count beyond store size");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> state_q == S_IDLE)
		else $error("final result while still working");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (cmd.op != OP_UNUSED) |=> busy)
		else $error("accepted command did not start work");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == ST_NOMATCH) |-> result.feature_index == '0 && result.last)
		else $error("no-match result malformed");

	a_matches_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= N_W'(MAX_MATCHES) || state_q == S_IDLE || state_q == S_CLEAR)
		else $error("match count overrun");

endmodule
